// ----- src/i2r_pkg.sv -----
// Package for the integer to radix string converter: sizes, types, helpers.
package i2r_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2d);
  localparam logic [CHAR_W-1:0] CHAR_NONE  = '0;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = RADIX_W'(10);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_READ,
    S_OUT,
    S_BAD
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d >= DEC_DIGITS) begin
      c = CHAR_W'(d) - CHAR_W'(DEC_DIGITS) + CHAR_A;
    end else begin
      c = CHAR_W'(d) + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

// ----- src/i2r_ifs.sv -----
// Stream interfaces: integer input channel and character output channel.
interface i2r_in_if;
  import i2r_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if;
  import i2r_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              bad_base;
  logic              last;

  modport source (output valid, output out_char, output bad_base, output last, input ready);
  modport sink   (input valid, input out_char, input bad_base, input last, output ready);
endinterface

// ----- src/integer_to_radix_string_top.sv -----
// Top level: integer to ASCII text in a configurable base, MSB character first.
//
//  channel    dir  payload                         transaction
//  num        in   value[31:0] signed              valid & ready
//  text       out  out_char[6:0], bad_base, last   valid & ready
//  cfg        in   cfg_wdata[5:0] = radix          cfg_we
//
//  Each digit is one run of the shared divider (one quotient bit per cycle),
//  then each character takes a store read and is then presented on the
//  output, where it may be stalled.
//  num.ready is high only in idle; text stalls simply hold the current char.
//  rst is synchronous and clears the sequencer; radix returns to 16.
module integer_to_radix_string_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [i2r_pkg::RADIX_W-1:0] cfg_wdata,
  i2r_in_if.sink                      num,
  i2r_out_if.source                   text
);
  import i2r_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [RADIX_W-1:0]     radix;
  logic [CNT_W-1:0]       cnt;
  logic                   negative_flag;
  logic                   radix_ok;
  logic                   in_acc;
  logic                   out_acc;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic [VALUE_WIDTH-1:0] dividend;
  logic [VALUE_WIDTH-1:0] quotient;
  logic [RADIX_W-1:0]     remainder;
  logic [RADIX_W-1:0]     rdata;
  logic                   st_we;
  logic                   st_re;
  div_ctl_t               div_ctl;
  div_stat_t              div_stat;

  assign radix_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
  assign in_acc    = num.valid && num.ready;
  assign out_acc   = text.valid && text.ready;
  assign magnitude = num.value[VALUE_WIDTH-1] ? (~num.value + VALUE_WIDTH'(1)) : num.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      negative_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc && radix_ok) begin
        cnt           <= '0;
        negative_flag <= num.value[VALUE_WIDTH-1];
      end else if (st_we) begin
        cnt <= cnt + CNT_W'(1);
      end else if (state == S_OUT && out_acc) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = radix_ok ? S_DIV : S_BAD;
        end
      end
      S_DIV: begin
        if (div_stat.done && quotient == '0) begin
          state_next = negative_flag ? S_SIGN : S_READ;
        end
      end
      S_SIGN: begin
        if (out_acc) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_next = (cnt == CNT_W'(1)) ? S_IDLE : S_READ;
        end
      end
      S_BAD: begin
        if (out_acc) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    num.ready     = (state == S_IDLE);
    st_we         = (state == S_DIV) && div_stat.done;
    st_re         = (state == S_READ);
    div_ctl.start = (in_acc && radix_ok) || (st_we && quotient != '0);
    dividend      = (state == S_IDLE) ? magnitude : quotient;
    text.valid    = 1'b0;
    text.out_char = CHAR_NONE;
    text.bad_base = 1'b0;
    text.last     = 1'b0;
    unique case (state)
      S_SIGN: begin
        text.valid    = 1'b1;
        text.out_char = CHAR_MINUS;
      end
      S_OUT: begin
        text.valid    = 1'b1;
        text.out_char = digit_char(rdata);
        text.last     = (cnt == CNT_W'(1));
      end
      S_BAD: begin
        text.valid    = 1'b1;
        text.bad_base = 1'b1;
        text.last     = 1'b1;
      end
      default: ;
    endcase
  end

  i2r_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (dividend),
    .divisor   (radix),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  i2r_digit_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (remainder),
    .re    (st_re),
    .raddr (IDX_W'(cnt - CNT_W'(1))),
    .rdata (rdata)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(text.valid && num.ready)) else $error("output valid while taking input");
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_stat.busy) else $error("divider restarted while busy");
  a_last_then_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && text.last) |=> num.ready) else $error("not idle after last char");
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.bad_base) |-> (text.last && text.out_char == CHAR_NONE))
    else $error("bad base transaction malformed");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (cnt != '0 && cnt <= CNT_W'(VALUE_WIDTH)))
    else $error("digit count out of range while emitting");

endmodule

// ----- src/i2r_divider.sv -----
// Shared restoring divider: one quotient bit per cycle, small divisor.
module i2r_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  i2r_pkg::div_ctl_t              ctl,
  input  logic [i2r_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [i2r_pkg::RADIX_W-1:0]    divisor,
  output i2r_pkg::div_stat_t             stat,
  output logic [i2r_pkg::VALUE_WIDTH-1:0] quotient,
  output logic [i2r_pkg::RADIX_W-1:0]    remainder
);
  import i2r_pkg::*;

  logic [VALUE_WIDTH-1:0] quo;
  logic [RADIX_W-1:0]     rem;
  logic [IDX_W-1:0]       bit_cnt;
  logic                   busy;
  logic                   done;
  logic [RADIX_W:0]       shifted;
  logic [RADIX_W:0]       diff;
  logic                   ge;

  always_comb begin
    shifted = {rem, quo[VALUE_WIDTH-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && bit_cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo     <= dividend;
      rem     <= '0;
      bit_cnt <= IDX_W'(VALUE_WIDTH - 1);
    end else if (busy) begin
      quo     <= {quo[VALUE_WIDTH-2:0], ge};
      rem     <= ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
      bit_cnt <= bit_cnt - IDX_W'(1);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("divider done without a run");
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor) else $error("remainder not below divisor");

endmodule

// ----- src/i2r_digit_store.sv -----
// Digit store: one write port, one registered read port.
module i2r_digit_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [i2r_pkg::IDX_W-1:0]   waddr,
  input  logic [i2r_pkg::RADIX_W-1:0] wdata,
  input  logic                        re,
  input  logic [i2r_pkg::IDX_W-1:0]   raddr,
  output logic [i2r_pkg::RADIX_W-1:0] rdata
);
  import i2r_pkg::*;

  logic [RADIX_W-1:0] mem [VALUE_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
